// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, constants and helper functions for the descriptor checksum block.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int ACC_W     = 40;
    localparam int SYM_W     = 5;
    localparam int POS_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int NUM_CHARS = 8;
    localparam int CNT_W     = 3;

    // two zero steps per cycle, eight zero steps in total
    localparam logic [CNT_W-1:0] STEP_LAST = 3'd3;
    localparam logic [CNT_W-1:0] CHAR_LAST = 3'(NUM_CHARS - 1);

    localparam logic [ACC_W-1:0] ACC_INIT = 40'h1;
    localparam logic [ACC_W-1:0] GEN0     = 40'hf5dee51989;
    localparam logic [ACC_W-1:0] GEN1     = 40'ha9fdca3312;
    localparam logic [ACC_W-1:0] GEN2     = 40'h1bab10e32d;
    localparam logic [ACC_W-1:0] GEN3     = 40'h3706b1677a;
    localparam logic [ACC_W-1:0] GEN4     = 40'h644d626ffd;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] pos;
    } t_pos;

    // finished accumulator handed from the accumulator to the finisher
    typedef struct packed {
        logic             valid;
        logic             bad;
        logic [ACC_W-1:0] acc;
    } t_fin_req;

    typedef struct packed {
        logic [CHAR_W-1:0] checksum_char;
        logic              bad_input;
        logic              last_result;
    } t_out_word;

    function automatic logic [ACC_W-1:0] pm_step(input logic [ACC_W-1:0] c,
                                                 input logic [SYM_W-1:0] v);
        logic [SYM_W-1:0] top;
        logic [ACC_W-1:0] r;
        top = c[ACC_W-1 -: SYM_W];
        r   = {c[ACC_W-SYM_W-1:0], {SYM_W{1'b0}}} ^ {{(ACC_W-SYM_W){1'b0}}, v};
        if (top[0]) r = r ^ GEN0;
        if (top[1]) r = r ^ GEN1;
        if (top[2]) r = r ^ GEN2;
        if (top[3]) r = r ^ GEN3;
        if (top[4]) r = r ^ GEN4;
        return r;
    endfunction

    // position of a byte in the 95-symbol input charset
    function automatic t_pos pos_of(input logic [7:0] b);
        t_pos       p;
        logic [7:0] d;
        p.ok = 1'b1;
        d    = 8'h00;
        case (b) inside
            [8'h30:8'h39]: d = b - 8'd48;   // 0-9
            8'h28:         d = 8'd10;       // (
            8'h29:         d = 8'd11;       // )
            8'h5b:         d = 8'd12;       // [
            8'h5d:         d = 8'd13;       // ]
            8'h2c:         d = 8'd14;       // ,
            8'h27:         d = 8'd15;       // apostrophe
            8'h2f:         d = 8'd16;       // /
            8'h2a:         d = 8'd17;       // *
            [8'h61:8'h68]: d = b - 8'd79;   // a-h
            8'h40:         d = 8'd26;       // @
            8'h3a:         d = 8'd27;       // :
            8'h24:         d = 8'd28;       // $
            8'h25:         d = 8'd29;       // %
            8'h7b:         d = 8'd30;       // {
            8'h7d:         d = 8'd31;       // }
            [8'h49:8'h5a]: d = b - 8'd41;   // I-Z
            8'h26:         d = 8'd50;       // &
            8'h2b:         d = 8'd51;       // +
            8'h2d:         d = 8'd52;       // -
            8'h2e:         d = 8'd53;       // .
            8'h3b:         d = 8'd54;       // ;
            8'h3c:         d = 8'd55;       // <
            8'h3d:         d = 8'd56;       // =
            8'h3e:         d = 8'd57;       // >
            8'h3f:         d = 8'd58;       // ?
            8'h21:         d = 8'd59;       // !
            8'h5e:         d = 8'd60;       // ^
            8'h5f:         d = 8'd61;       // _
            8'h7c:         d = 8'd62;       // |
            8'h7e:         d = 8'd63;       // ~
            [8'h69:8'h7a]: d = b - 8'd41;   // i-z
            [8'h41:8'h48]: d = b + 8'd17;   // A-H
            8'h60:         d = 8'd90;       // backtick
            8'h23:         d = 8'd91;       // #
            8'h22:         d = 8'd92;       // double quote
            8'h5c:         d = 8'd93;       // backslash
            8'h20:         d = 8'd94;       // space
            default:       p.ok = 1'b0;
        endcase
        p.pos = d[POS_W-1:0];
        return p;
    endfunction

    function automatic logic [CHAR_W-1:0] out_char(input logic [SYM_W-1:0] s);
        logic [CHAR_W-1:0] c;
        case (s)
            5'd0:    c = "q";
            5'd1:    c = "p";
            5'd2:    c = "z";
            5'd3:    c = "r";
            5'd4:    c = "y";
            5'd5:    c = "9";
            5'd6:    c = "x";
            5'd7:    c = "8";
            5'd8:    c = "g";
            5'd9:    c = "f";
            5'd10:   c = "2";
            5'd11:   c = "t";
            5'd12:   c = "v";
            5'd13:   c = "d";
            5'd14:   c = "w";
            5'd15:   c = "0";
            5'd16:   c = "s";
            5'd17:   c = "3";
            5'd18:   c = "j";
            5'd19:   c = "n";
            5'd20:   c = "5";
            5'd21:   c = "4";
            5'd22:   c = "k";
            5'd23:   c = "h";
            5'd24:   c = "c";
            5'd25:   c = "e";
            5'd26:   c = "6";
            5'd27:   c = "m";
            5'd28:   c = "u";
            5'd29:   c = "a";
            5'd30:   c = "7";
            default: c = "l";
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/dcs_ifs.sv =====
// ----------------------------------------------------------------------------
// dcs_ifs
// Valid/ready channel interfaces for descriptor bytes and checksum words.
// ----------------------------------------------------------------------------
interface dcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, output symbol_byte, output has_byte,
                    output is_last, input ready);
    modport sink   (input valid, input symbol_byte, input has_byte,
                    input is_last, output ready);
endinterface

interface dcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] checksum_char;
    logic       bad_input;
    logic       last_result;

    modport source (output valid, output checksum_char, output bad_input,
                    output last_result, input ready);
    modport sink   (input valid, input checksum_char, input bad_input,
                    input last_result, output ready);
endinterface

// ===== hdl/dcs_acc.sv =====
// ----------------------------------------------------------------------------
// dcs_acc
// Per-byte polymod accumulator with group folding and a handoff register
// that holds the finished accumulator of a string until the finisher takes it.
// ----------------------------------------------------------------------------
module dcs_acc (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    input  logic                     i_has,
    input  logic                     i_last,
    input  logic                     i_take,
    output dcs_pkg::t_fin_req        o_req
);

    logic [dcs_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [dcs_pkg::SYM_W-1:0] r_gs, n_gs;
    logic [1:0]                r_fill, n_fill;
    logic                      r_bad, n_bad;
    dcs_pkg::t_fin_req         r_req, n_req;

    dcs_pkg::t_pos             lk;
    logic [dcs_pkg::ACC_W-1:0] acc_a, acc_b, acc_fin;
    logic [dcs_pkg::SYM_W-1:0] gs_a;
    logic [1:0]                fill_a;

    always_comb begin
        lk     = dcs_pkg::pos_of(i_byte);
        acc_b  = r_acc;
        gs_a   = r_gs;
        fill_a = r_fill;
        n_bad  = r_bad | (i_has & ~lk.ok);
        acc_a  = dcs_pkg::pm_step(r_acc, lk.pos[dcs_pkg::SYM_W-1:0]);
        if (i_has && lk.ok && !r_bad) begin
            // group symbol: base-3 fold of the position's upper bits
            gs_a   = {r_gs[3:0], 1'b0} + r_gs + {3'b000, lk.pos[6:5]};
            fill_a = r_fill + 2'd1;
            acc_b  = acc_a;
            if (fill_a == 2'd3) begin
                acc_b  = dcs_pkg::pm_step(acc_a, gs_a);
                gs_a   = '0;
                fill_a = 2'd0;
            end
        end
        // flush a partial group at the end of the string
        acc_fin = (fill_a != 2'd0) ? dcs_pkg::pm_step(acc_b, gs_a) : acc_b;

        n_acc  = r_acc;
        n_gs   = r_gs;
        n_fill = r_fill;
        n_req  = r_req;
        if (i_take) begin
            n_req.valid = 1'b0;
        end
        if (i_fire) begin
            if (i_last) begin
                n_req.valid = 1'b1;
                n_req.bad   = n_bad;
                n_req.acc   = acc_fin;
                n_acc       = dcs_pkg::ACC_INIT;
                n_gs        = '0;
                n_fill      = 2'd0;
                n_bad       = 1'b0;
            end else begin
                n_acc  = acc_b;
                n_gs   = gs_a;
                n_fill = fill_a;
            end
        end else begin
            n_bad = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= dcs_pkg::ACC_INIT;
            r_gs        <= '0;
            r_fill      <= 2'd0;
            r_bad       <= 1'b0;
            r_req.valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_gs        <= n_gs;
            r_fill      <= n_fill;
            r_bad       <= n_bad;
            r_req.valid <= n_req.valid;
        end
        r_req.bad <= n_req.bad;
        r_req.acc <= n_req.acc;
    end

    assign o_req = r_req;

endmodule

// ===== hdl/dcs_fin.sv =====
// ----------------------------------------------------------------------------
// dcs_fin
// Runs the eight zero steps on a finished accumulator and sends out the
// eight checksum characters, or one error word, through an output register.
// ----------------------------------------------------------------------------
module dcs_fin (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcs_pkg::t_fin_req    i_req,
    output logic                 o_take,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output dcs_pkg::t_out_word   o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [dcs_pkg::ACC_W-1:0]  r_fin, n_fin;
    logic                       r_bad, n_bad;
    logic [dcs_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ov, n_ov;
    dcs_pkg::t_out_word         r_word, n_word;

    logic                       slot_free;
    logic [dcs_pkg::ACC_W-1:0]  two_steps;

    assign slot_free = !r_ov || i_out_ready;
    assign o_take    = i_req.valid && (r_state == S_IDLE);

    always_comb begin
        two_steps = dcs_pkg::pm_step(dcs_pkg::pm_step(r_fin, '0), '0);
        n_state   = r_state;
        n_fin     = r_fin;
        n_bad     = r_bad;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_ov      = r_ov && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_fin   = i_req.acc;
                    n_bad   = i_req.bad;
                    n_cnt   = '0;
                    n_state = i_req.bad ? S_EMIT : S_STEP;
                end
            end
            S_STEP: begin
                n_fin = two_steps;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == dcs_pkg::STEP_LAST) begin
                    n_fin   = two_steps ^ dcs_pkg::ACC_INIT;
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (r_bad) begin
                        n_word.checksum_char = '0;
                        n_word.bad_input     = 1'b1;
                        n_word.last_result   = 1'b1;
                        n_state              = S_IDLE;
                    end else begin
                        // most significant symbol first
                        n_word.checksum_char =
                            dcs_pkg::out_char(r_fin[dcs_pkg::ACC_W-1 -: dcs_pkg::SYM_W]);
                        n_word.bad_input     = 1'b0;
                        n_word.last_result   = (r_cnt == dcs_pkg::CHAR_LAST);
                        n_fin = {r_fin[dcs_pkg::ACC_W-dcs_pkg::SYM_W-1:0],
                                 {dcs_pkg::SYM_W{1'b0}}};
                        n_cnt = r_cnt + 3'd1;
                        if (r_cnt == dcs_pkg::CHAR_LAST) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_fin  <= n_fin;
        r_bad  <= n_bad;
        r_word <= n_word;
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_word;

endmodule

// ===== hdl/descriptor_checksum.sv =====
// ----------------------------------------------------------------------------
// descriptor_checksum
// Streaming output descriptor checksum: bytes in, eight checksum characters
// (or one error word) out at the end of each string.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                  | word
//  i_in    | in  | symbol_byte, has_byte, is_last          | one text byte
//  o_out   | out | checksum_char, bad_input, last_result   | one result
//
//  one byte per cycle; a byte is folded into the accumulator in the cycle
//  it is taken. the finisher takes an ended string, runs the zero steps on a
//  good one and sends 8 characters (one per cycle when o_out is ready).
//  input stalls only after a string ends while the finisher is still busy
//  with the previous one; ready then stays low until the finisher takes it.
//  synchronous active-low reset clears all control state.
// ----------------------------------------------------------------------------
module descriptor_checksum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcs_in_if.sink     i_in,
    dcs_out_if.source  o_out
);

    dcs_pkg::t_fin_req   req;
    dcs_pkg::t_out_word  word;
    logic                take;
    logic                fire;
    logic                out_valid;

    // the held string leaves in the same cycle it is taken
    assign i_in.ready = !req.valid || take;
    assign fire       = i_in.valid && i_in.ready;

    dcs_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in.symbol_byte),
        .i_has   (i_in.has_byte),
        .i_last  (i_in.is_last),
        .i_take  (take),
        .o_req   (req)
    );

    dcs_fin u_fin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_take      (take),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out       (word)
    );

    assign o_out.valid         = out_valid;
    assign o_out.checksum_char = word.checksum_char;
    assign o_out.bad_input     = word.bad_input;
    assign o_out.last_result   = word.last_result;

endmodule

// ===== hdl/dcs_checker.sv =====
// ----------------------------------------------------------------------------
// dcs_checker
// Port-level assertions for the descriptor checksum block.
// ----------------------------------------------------------------------------
module dcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_bad,
    input logic       i_out_last
);

    // no result word right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    // an error word is a single last word with no character
    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_last && (i_out_char == 8'h00))
        else $error("malformed error word");

    // checksum characters are printable charset letters and digits
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_bad |-> (i_out_char >= 8'h30) && (i_out_char <= 8'h7a))
        else $error("checksum character out of range");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_bad) && $stable(i_out_last))
        else $error("stalled result word changed");

endmodule

bind descriptor_checksum dcs_checker u_dcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.checksum_char),
    .i_out_bad   (o_out.bad_input),
    .i_out_last  (o_out.last_result)
);
